>>> design/spatial_hash_height_cache_unit_macros.svh
// Assertion macros for the spatial hash height cache modules; used by shhc_back.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SPATIAL_HASH_HEIGHT_CACHE_UNIT_MACROS_SVH
`define SPATIAL_HASH_HEIGHT_CACHE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SHHC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("shhc: check failed");

// A condition that, when true, must be followed by another in the next cycle.
`define SHHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shhc: check failed");

`endif

>>> design/shhc_pkg.sv
// Package for the spatial hash height cache: sizes, codes, word types.
// Used by every module of the block but shhc_ram; depends on nothing.
`default_nettype none

package shhc_pkg;

  // Number of slots; the slot index is the low bits of the hash, so this is a power of two.
  localparam int ENTRIES   = 512;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int FRAC_BITS = 8;

  localparam int COORD_W   = 32;
  // Room for a coordinate times ten.
  localparam int SCALED_W  = COORD_W + 4;
  localparam int RAM_W     = 1 + 3 * COORD_W;

  localparam logic [COORD_W-1:0]  PRIME_X = 32'd73856093;
  localparam logic [COORD_W-1:0]  PRIME_Y = 32'd19349663;
  localparam logic [SCALED_W-1:0] ROUND_BIAS = SCALED_W'((64'd1 << FRAC_BITS) - 64'd1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int TOL_W = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd13;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] height_in;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] height_out;
  } out_item_t;

  // What the back end has to do with a queued word.
  typedef enum logic [1:0] {
    K_LOOKUP = 2'd0,
    K_MISS   = 2'd1,
    K_INSERT = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] h;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] h;
  } slot_t;

endpackage

`default_nettype wire

>>> design/spatial_hash_height_cache_unit.sv
// Top level of the spatial hash height cache: front end, command queue, back end.
// Uses shhc_pkg, shhc_front, shhc_queue and shhc_back.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    shhc_pkg::in_item_t
//   out      output     out_valid/out_ready  shhc_pkg::out_item_t
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word passes the three-stage hash pipeline, then waits in a two-word queue.
// The back end writes an insert from its idle state and takes a lookup through
// the idle and read states, set by the registered read of the slot memory; a
// clear sweeps every slot. After reset the same sweep runs with in_ready held low.
// A waiting result does not stop the front end; a full queue stalls it.
// Configuration writes are taken in every cycle.
`default_nettype none

module spatial_hash_height_cache_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire shhc_pkg::in_item_t              in_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      shhc_pkg::out_item_t             out_data,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [shhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shhc_pkg::TOL_W-1:0]      cfg_data
);

  import shhc_pkg::*;

  logic             push_valid, push_ready;
  cmd_t             push_data;
  logic             q_valid, q_pop;
  cmd_t             q_data;
  logic [TOL_W-1:0] tolerance;
  logic             init_busy;

  assign cfg_ready = 1'b1;

  shhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .tolerance (tolerance),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  shhc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  shhc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .tolerance(tolerance),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> design/shhc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module shhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/shhc_front.sv
// Front end: configuration registers, input acceptance, classification and the
// three-stage slot hash pipeline feeding the command queue. Uses shhc_pkg.
`default_nettype none

module shhc_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire shhc_pkg::in_item_t              in_data,
  input  wire logic                            cfg_valid,
  input  wire logic [shhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shhc_pkg::TOL_W-1:0]      cfg_data,
  input  wire logic                            init_busy,
  output      logic [shhc_pkg::TOL_W-1:0]      tolerance,
  output      logic                            push_valid,
  input  wire logic                            push_ready,
  output      shhc_pkg::cmd_t                  push_data
);

  import shhc_pkg::*;

  logic             enable_r;
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      tol_r    <= TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:    enable_r <= cfg_data[0];
        REG_TOLERANCE: tol_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign tolerance = tol_r;

  // Stage valid and keep flags; a word without keep makes no queue entry.
  logic v1_r, v2_r, v3_r;
  logic k1_r, k2_r, k3_r;
  kind_t kind1_r, kind2_r, kind3_r;
  logic [COORD_W-1:0] x1_r, y1_r, h1_r;
  logic [COORD_W-1:0] x2_r, y2_r, h2_r;
  logic [COORD_W-1:0] x3_r, y3_r, h3_r;
  logic [COORD_W-1:0] sx2_r, sy2_r;
  logic [COORD_W-1:0] hx3_r, hy3_r;

  logic  adv;
  logic  in_fire;
  kind_t kind1_nxt;
  logic  k1_nxt;

  assign adv      = !v3_r || !k3_r || push_ready;
  assign in_ready = adv && !init_busy;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    kind1_nxt = K_LOOKUP;
    k1_nxt    = 1'b1;
    case (in_data.operation)
      OP_LOOKUP: kind1_nxt = enable_r ? K_LOOKUP : K_MISS;
      OP_INSERT: begin
        kind1_nxt = K_INSERT;
        k1_nxt    = enable_r;
      end
      OP_CLEAR:  kind1_nxt = K_CLEAR;
      default:   k1_nxt    = 1'b0;
    endcase
  end

  // Coordinate times ten, divided by the fraction scale with truncation toward zero.
  function automatic logic [COORD_W-1:0] scale_ten(input logic [COORD_W-1:0] c);
    logic signed [SCALED_W-1:0] ce;
    logic signed [SCALED_W-1:0] p;
    logic signed [SCALED_W-1:0] q;
    ce = $signed({{(SCALED_W-COORD_W){c[COORD_W-1]}}, c});
    p  = (ce <<< 3) + (ce <<< 1);
    if (p[SCALED_W-1]) begin
      p = p + $signed(ROUND_BIAS);
    end
    q = p >>> FRAC_BITS;
    return q[COORD_W-1:0];
  endfunction

  logic [COORD_W-1:0] sx_nxt, sy_nxt, hx_nxt, hy_nxt, hash;

  assign sx_nxt = scale_ten(x1_r);
  assign sy_nxt = scale_ten(y1_r);
  assign hx_nxt = sx2_r * PRIME_X;
  assign hy_nxt = sy2_r * PRIME_Y;
  assign hash   = hx3_r ^ hy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r    <= k1_nxt;
      kind1_r <= kind1_nxt;
      x1_r    <= in_data.coord_x;
      y1_r    <= in_data.coord_y;
      h1_r    <= in_data.height_in;
      k2_r    <= k1_r;
      kind2_r <= kind1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      h2_r    <= h1_r;
      sx2_r   <= sx_nxt;
      sy2_r   <= sy_nxt;
      k3_r    <= k2_r;
      kind3_r <= kind2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      h3_r    <= h2_r;
      hx3_r   <= hx_nxt;
      hy3_r   <= hy_nxt;
    end
  end

  assign push_valid     = v3_r && k3_r;
  assign push_data.kind = kind3_r;
  assign push_data.idx  = hash[IDX_W-1:0];
  assign push_data.x    = x3_r;
  assign push_data.y    = y3_r;
  assign push_data.h    = h3_r;

endmodule

`default_nettype wire

>>> design/shhc_queue.sv
// Short command queue between the front and back ends of the height cache.
// Uses shhc_pkg for the command word and its depth.
`default_nettype none

module shhc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output      logic           push_ready,
  input  wire shhc_pkg::cmd_t push_data,
  output      logic           pop_valid,
  input  wire logic           pop,
  output      shhc_pkg::cmd_t pop_data
);

  import shhc_pkg::*;

  cmd_t               slots_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/shhc_back.sv
// Back end: slot memory with valid marks, clearing sweep, lookup compare and
// the result register. Uses shhc_pkg, shhc_ram and the assertion macros.
`default_nettype none
`include "spatial_hash_height_cache_unit_macros.svh"

module shhc_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output      logic                       q_pop,
  input  wire shhc_pkg::cmd_t             q_data,
  input  wire logic [shhc_pkg::TOL_W-1:0] tolerance,
  output      logic                       init_busy,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      shhc_pkg::out_item_t        out_data
);

  import shhc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             init_r, init_nxt;
  logic [COORD_W-1:0] qx_r, qy_r;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;

  logic      out_valid_r, out_free, out_load;
  out_item_t out_data_r, out_data_nxt;

  shhc_ram #(
    .WIDTH(RAM_W),
    .DEPTH(ENTRIES)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Differences are taken one bit wider so they never wrap.
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        ax, ay;
  logic                    hit;

  assign dx  = $signed({ram_rdata.x[COORD_W-1], ram_rdata.x}) - $signed({qx_r[COORD_W-1], qx_r});
  assign dy  = $signed({ram_rdata.y[COORD_W-1], ram_rdata.y}) - $signed({qy_r[COORD_W-1], qy_r});
  assign ax  = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
  assign ay  = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
  assign hit = ram_rdata.valid
               && (ax < (COORD_W+1)'(tolerance))
               && (ay < (COORD_W+1)'(tolerance));

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    init_nxt     = init_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = q_data.idx;
    ram_raddr    = q_data.idx;
    ram_wdata    = {1'b1, q_data.x, q_data.y, q_data.h};
    out_load     = 1'b0;
    out_data_nxt = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            K_LOOKUP: begin
              q_pop     = 1'b1;
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
            K_MISS: begin
              if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
              end
            end
            K_INSERT: begin
              q_pop  = 1'b1;
              ram_we = 1'b1;
            end
            K_CLEAR: begin
              q_pop       = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_data_nxt.hit        = hit;
          out_data_nxt.height_out = hit ? ram_rdata.h : '0;
          state_nxt               = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
          init_nxt  = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      init_r    <= init_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      qx_r <= q_data.x;
      qy_r <= q_data.y;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SHHC_ASSERT(a_no_rw_overlap, !(ram_we && ram_re))
  `SHHC_ASSERT(a_no_pop_in_sweep, !((state_r == S_CLEAR) && q_pop))
  `SHHC_ASSERT_NEXT(a_lookup_reads, (state_r == S_IDLE) && ram_re, state_r == S_READ)
  `SHHC_ASSERT_NEXT(a_read_delivers, (state_r == S_READ) && out_free,
                    out_valid_r && (state_r == S_IDLE))
  `SHHC_ASSERT(a_init_only_sweeping, !init_r || (state_r == S_CLEAR))

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for spatial_hash_height_cache_unit: a shadow cache predicts every lookup
// answer, a clocked driver and monitor exercise all three channels. Uses shhc_pkg and the DUT.

module tb_top;
  import shhc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } spot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0] cfg_data = '0;

  // Shadow copy of the cache contents and its two registers.
  logic signed [COORD_W-1:0] mirror_x [ENTRIES];
  logic signed [COORD_W-1:0] mirror_y [ENTRIES];
  logic signed [COORD_W-1:0] mirror_h [ENTRIES];
  bit mirror_valid [ENTRIES];
  logic mirror_enable = 1'b1;
  logic [TOL_W-1:0] mirror_tol = TOL_RESET;

  in_item_t pending_words[$];
  out_item_t lookup_answers[$];
  spot_t recent_spots[$];

  bit calm = 1'b0;
  bit pressure_req = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int items_taken = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int errors = 0;
  int tol_rand;
  out_item_t due;

  spatial_hash_height_cache_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scale by ten with truncation toward zero, then the two prime products XORed.
  function automatic logic [IDX_W-1:0] slot_index(logic signed [COORD_W-1:0] x,
                                                  logic signed [COORD_W-1:0] y);
    longint tx, ty;
    logic [COORD_W-1:0] hx, hy;
    tx = (longint'(x) * 10) / (longint'(1) << FRAC_BITS);
    ty = (longint'(y) * 10) / (longint'(1) << FRAC_BITS);
    hx = tx[COORD_W-1:0] * PRIME_X;
    hy = ty[COORD_W-1:0] * PRIME_Y;
    return IDX_W'((hx ^ hy) % ENTRIES);
  endfunction

  function automatic longint coord_gap(logic signed [COORD_W-1:0] a,
                                       logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  task automatic cache_access(in_item_t it);
    logic [IDX_W-1:0] idx;
    out_item_t answer;
    answer = '0;
    idx = slot_index(it.coord_x, it.coord_y);
    case (it.operation)
      OP_CLEAR: begin
        foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;
      end
      OP_INSERT: begin
        if (mirror_enable) begin
          mirror_x[idx] = it.coord_x;
          mirror_y[idx] = it.coord_y;
          mirror_h[idx] = it.height_in;
          mirror_valid[idx] = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (mirror_enable && mirror_valid[idx]
            && coord_gap(mirror_x[idx], it.coord_x) < longint'(mirror_tol)
            && coord_gap(mirror_y[idx], it.coord_y) < longint'(mirror_tol)) begin
          answer.hit = 1'b1;
          answer.height_out = mirror_h[idx];
        end
        lookup_answers.push_back(answer);
      end
      default: ;
    endcase
  endtask

  // Input side: one word at a time, refilled on a free slot, with random gaps unless calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cache_access(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each accepted word and runs the long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (lookup_answers.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual hit=%0d height=%0d",
                   $time, out_data.hit, out_data.height_out);
          errors++;
        end else begin
          due = lookup_answers.pop_front();
          if (out_data.hit !== due.hit) begin
            $display("%0t: hit mismatch: expected %0d, actual %0d",
                     $time, due.hit, out_data.hit);
            errors++;
          end
          if (out_data.height_out !== due.height_out) begin
            $display("%0t: height mismatch: expected %0d, actual %0d",
                     $time, due.height_out, out_data.height_out);
            errors++;
          end
          if (due.hit) hits_seen++;
        end
      end
      if (pressure_req && !pressure_done) begin
        hold_left <= 400;
        pressure_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 21);
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE:    mirror_enable = val[0];
      REG_TOLERANCE: mirror_tol = val;
      default: ;
    endcase
  endtask

  task automatic push_item(logic [1:0] op, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] h);
    in_item_t it;
    it.operation = op;
    it.coord_x = x;
    it.coord_y = y;
    it.height_in = h;
    pending_words.push_back(it);
  endtask

  // Waits until every word has gone in and every answer has come out, then lets a
  // possible clear sweep finish before anything else happens.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || lookup_answers.size() != 0)
      @(posedge clk);
    repeat (ENTRIES + 32) @(posedge clk);
  endtask

  // Finds a coordinate at which the two extremes of the other axis share a slot, so
  // that a wrapped difference of one would wrongly look like a match.
  function automatic logic signed [COORD_W-1:0] shared_slot_partner(bit along_y);
    logic signed [COORD_W-1:0] c;
    int k;
    for (k = 0; k < 200000; k++) begin
      c = k * 37;
      if (!along_y && slot_index(C_MAX, c) == slot_index(C_MIN, c)) return c;
      if (along_y && slot_index(c, C_MAX) == slot_index(c, C_MIN)) return c;
    end
    return 0;
  endfunction

  function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] c, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    return c + d;
  endfunction

  function automatic logic signed [COORD_W-1:0] fresh_coord();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
    return $urandom;
  endfunction

  // Mostly lookups near recently inserted spots, mixed with inserts and some noise.
  task automatic add_random_items(int count, int clear_pct);
    int n, r, span;
    spot_t s;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      span = ($urandom_range(0, 3) == 0) ? 300 : int'(mirror_tol) + 2;
      if (r < clear_pct) begin
        push_item(OP_CLEAR, $urandom, $urandom, $urandom);
      end else if (r < clear_pct + 3) begin
        push_item(OP_NONE, $urandom, $urandom, $urandom);
      end else if (r < 40) begin
        if (recent_spots.size() != 0 && $urandom_range(0, 99) < 30) begin
          s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
          s.x = nudge(s.x, span);
          s.y = nudge(s.y, span);
        end else begin
          s.x = fresh_coord();
          s.y = fresh_coord();
        end
        recent_spots.push_back(s);
        if (recent_spots.size() > 24) void'(recent_spots.pop_front());
        push_item(OP_INSERT, s.x, s.y, $urandom);
      end else begin
        if (recent_spots.size() != 0 && $urandom_range(0, 99) < 70) begin
          s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
          s.x = nudge(s.x, span);
          s.y = nudge(s.y, span);
        end else begin
          s.x = fresh_coord();
          s.y = fresh_coord();
        end
        push_item(OP_LOOKUP, s.x, s.y, $urandom);
      end
    end
  endtask

  initial begin
    logic signed [COORD_W-1:0] wx, wy;
    wy = shared_slot_partner(1'b0);
    wx = shared_slot_partner(1'b1);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_register(REG_ENABLE, 8'd1);
    write_register(REG_TOLERANCE, TOL_RESET);
    // Tolerance edges, truncation toward zero for negatives, overwrite, extremes, clear.
    push_item(OP_INSERT, 0, 0, C_MAX);
    push_item(OP_LOOKUP, 0, 0, 0);
    push_item(OP_LOOKUP, 12, 0, 0);
    push_item(OP_LOOKUP, 13, 0, 0);
    push_item(OP_LOOKUP, -12, -12, 0);
    push_item(OP_LOOKUP, 0, -13, 0);
    push_item(OP_INSERT, 5, 5, 1234);
    push_item(OP_LOOKUP, 0, 0, 0);
    push_item(OP_INSERT, C_MIN, C_MIN, C_MIN);
    push_item(OP_LOOKUP, C_MIN, C_MIN, 0);
    push_item(OP_INSERT, C_MAX, C_MAX, -1);
    push_item(OP_LOOKUP, C_MAX - 12, C_MAX, 0);
    push_item(OP_INSERT, C_MAX, wy, 77);
    push_item(OP_LOOKUP, C_MIN, wy, 0);
    push_item(OP_INSERT, wx, C_MAX, 88);
    push_item(OP_LOOKUP, wx, C_MIN, 0);
    push_item(OP_LOOKUP, C_MAX, wy, 0);
    push_item(OP_NONE, $urandom, $urandom, $urandom);
    push_item(OP_NONE, -1, -1, -1);
    push_item(OP_CLEAR, 0, 0, 0);
    push_item(OP_LOOKUP, 0, 0, 0);
    push_item(OP_LOOKUP, C_MAX, C_MAX, 0);
    push_item(OP_INSERT, -1000, 2000, 32'sh5A5A_5A5A);
    push_item(OP_LOOKUP, -1000, 2000, 0);
    drain();

    // Widest tolerance, run back to back with no idling on either side.
    write_register(REG_TOLERANCE, 8'd255);
    calm = 1'b1;
    add_random_items(250, 1);
    drain();
    calm = 1'b0;

    // The receiver stops for a long stretch while words keep coming in.
    write_register(REG_TOLERANCE, 8'd40);
    add_random_items(250, 1);
    pressure_req = 1'b1;
    drain();

    // With a zero tolerance nothing can hit; the last insert is checked later.
    write_register(REG_TOLERANCE, 8'd0);
    push_item(OP_INSERT, 300, 300, 42);
    push_item(OP_LOOKUP, 300, 300, 0);
    add_random_items(100, 1);
    push_item(OP_INSERT, 900, 900, 555);
    drain();

    // Disabled: lookups miss, inserts are dropped, a clear still clears.
    write_register(REG_ENABLE, 8'd0);
    write_register(REG_TOLERANCE, TOL_RESET);
    push_item(OP_LOOKUP, 900, 900, 0);
    push_item(OP_INSERT, 900, 900, -555);
    drain();
    write_register(REG_ENABLE, 8'd1);
    push_item(OP_LOOKUP, 900, 900, 0);
    drain();
    write_register(REG_ENABLE, 8'd0);
    push_item(OP_CLEAR, 0, 0, 0);
    push_item(OP_LOOKUP, 0, 0, 0);
    add_random_items(100, 2);
    drain();
    write_register(REG_ENABLE, 8'd1);
    push_item(OP_LOOKUP, 900, 900, 0);
    drain();

    tol_rand = $urandom_range(1, 254);
    write_register(REG_TOLERANCE, TOL_W'(tol_rand));
    add_random_items(250, 1);
    drain();

    $display("Sent %0d words and checked %0d lookup results, %0d of them hits.",
             items_taken, results_seen, hits_seen);
    $display("Tolerances 13, 255, 40, 0 and %0d, with the cache disabled and re-enabled.",
             tol_rand);
    if (errors == 0 && lookup_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run stopped at %0t: words still in flight.", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
